>>> src/stb_pkg.sv
`timescale 1ns / 1ps

package stb_pkg;

  // Bank dimensions
  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Field widths fixed by the interface
  localparam int CMD_W       = 3;
  localparam int TIDX_W      = 3;
  localparam int PERIOD_W    = 32;
  localparam int DIVIDE_W    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_ENABLE = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic apply;       // apply a slot command from the input item
    logic tick;        // advance the prescaler
    logic walk_clear;  // restart walk index and result count
    logic walking;     // slot address follows the walk index
    logic walk_step;   // process the current walk slot
    logic flush;       // move the held result out as the last of the run
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_cmd;    // input item is a tick
    logic expire;      // prescaler expires on this tick
    logic step_emit;   // current walk slot produces a result
    logic walk_last;   // current walk slot is the final one
    logic pend_valid;  // a result is held waiting for its successor
    logic out_free;    // output register can take a result this cycle
  } ctrl_status_t;

endpackage

>>> src/software_timer_bank.sv
`timescale 1ns / 1ps

// Bank of countdown timers sharing one tick prescaler.
// Input channel (in_valid/in_ready) carries one command item: start, stop,
// pause, resume for the slot in timer_index, or a raw tick.
// Output channel (out_valid/out_ready) carries one item per reported timeout:
// the expired slot and a flag on the final timeout of that tick.
// Configuration (cfg_write/cfg_index/cfg_data) sets the prescaler reload and
// the timeout notification enable; write it only while the bank is idle.
// Slot commands and ticks that do not expire the prescaler are handled as
// they are accepted, and the bank stays idle for the next item. An expiring
// tick is accepted, then walks every slot in turn through the shared decrement
// path and ends with a final flush. Each timeout is registered into the output
// when the next timeout is found, the last one after the walk ends.
// A stalled receiver holds back the walk only when a second timeout is found
// while the output register is still full, and holds the flush until the output
// register has room; new commands are taken while the last timeout waits there.
// Reset stops every timer, sets the prescaler to one, the divide to one and
// notifications on, and empties the output register.
module software_timer_bank (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [stb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stb_pkg::CMD_W-1:0]        command,
  input  logic [stb_pkg::TIDX_W-1:0]       timer_index,
  input  logic [stb_pkg::PERIOD_W-1:0]     period,
  input  logic                             auto_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stb_pkg::TIDX_W-1:0]       expired_timer,
  output logic                             last_of_run
);
  import stb_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequence commands and the timer walk
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold timer state, prescaler and output register
  stb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .timer_index   (timer_index),
    .period        (period),
    .auto_restart  (auto_restart),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .expired_timer (expired_timer),
    .last_of_run   (last_of_run)
  );

endmodule

>>> src/stb_datapath.sv
`timescale 1ns / 1ps

module stb_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [stb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [stb_pkg::CMD_W-1:0]        command,
  input  logic [stb_pkg::TIDX_W-1:0]       timer_index,
  input  logic [stb_pkg::PERIOD_W-1:0]     period,
  input  logic                             auto_restart,
  input  stb_pkg::ctrl_cmd_t               cmd,
  output stb_pkg::ctrl_status_t            status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [stb_pkg::TIDX_W-1:0]       expired_timer,
  output logic                             last_of_run
);
  import stb_pkg::*;

  logic [DIVIDE_W-1:0]    tick_divide;
  logic                   notify_enable;
  logic [DIVIDE_W-1:0]    prescale_count;
  logic [DIVIDE_W-1:0]    prescale_dec;

  mode_t                  mode        [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_value[NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] remaining   [NUM_TIMERS];
  logic                   restart_flag[NUM_TIMERS];

  logic [IDX_W-1:0]       walk_idx;
  logic [RES_CNT_W-1:0]   emit_cnt;
  logic                   pend_valid;
  logic [IDX_W-1:0]       pend_idx;

  logic [IDX_W-1:0]       slot;
  logic                   idx_ok;
  logic [COUNT_WIDTH-1:0] start_count;
  mode_t                  slot_mode;
  logic [COUNT_WIDTH-1:0] slot_rem;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic                   hits_zero;
  logic                   running;
  logic                   out_free;
  logic                   push_pend;

  // Decode the input item
  assign idx_ok      = 32'(timer_index) < 32'(NUM_TIMERS);
  assign start_count = COUNT_WIDTH'(period);
  assign slot        = cmd.walking ? walk_idx : IDX_W'(timer_index);

  // Read the addressed slot and compute its countdown
  assign slot_mode = mode[slot];
  assign slot_rem  = remaining[slot];
  assign rem_dec   = (slot_rem != '0) ? slot_rem - COUNT_WIDTH'(1) : '0;
  assign hits_zero = rem_dec == '0;
  assign running   = slot_mode == MODE_RUNNING;

  assign prescale_dec = (prescale_count != '0) ? prescale_count - DIVIDE_W'(1) : '0;

  assign out_free  = !out_valid || out_ready;
  assign push_pend = cmd.walk_step && status.step_emit && pend_valid;

  always_comb begin
    status.tick_cmd   = command == CMD_TICK;
    status.expire     = prescale_dec == '0;
    status.step_emit  = running && hits_zero && notify_enable &&
                        (emit_cnt < RES_CNT_W'(MAX_RESULTS));
    status.walk_last  = walk_idx == IDX_W'(NUM_TIMERS - 1);
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide   <= DIVIDE_W'(1);
      notify_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICK_DIVIDE:   tick_divide   <= cfg_data;
        CFG_NOTIFY_ENABLE: notify_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Prescaler: drop toward zero, reload on expiry
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= DIVIDE_W'(1);
    end else if (cmd.tick) begin
      prescale_count <= status.expire ? tick_divide : prescale_dec;
    end
  end

  // Timer modes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        mode[i] <= MODE_STOPPED;
      end
    end else if (cmd.apply && idx_ok) begin
      case (command)
        CMD_START: begin
          if (slot_mode == MODE_STOPPED && start_count != '0) mode[slot] <= MODE_RUNNING;
        end
        CMD_STOP: mode[slot] <= MODE_STOPPED;
        CMD_PAUSE: begin
          if (slot_mode == MODE_RUNNING) mode[slot] <= MODE_PAUSED;
        end
        CMD_RESUME: begin
          if (slot_mode == MODE_PAUSED) mode[slot] <= MODE_RUNNING;
        end
        default: ;
      endcase
    end else if (cmd.walk_step && running && hits_zero && !restart_flag[slot]) begin
      mode[slot] <= MODE_STOPPED;
    end
  end

  // Counts, reload values and restart options
  always_ff @(posedge clk) begin
    if (cmd.apply && idx_ok && command == CMD_START &&
        slot_mode == MODE_STOPPED && start_count != '0) begin
      reload_value[slot] <= start_count;
      remaining[slot]    <= start_count;
      restart_flag[slot] <= auto_restart;
    end else if (cmd.walk_step && running) begin
      remaining[slot] <= (hits_zero && restart_flag[slot]) ? reload_value[slot] : rem_dec;
    end
  end

  // Walk index and result count
  always_ff @(posedge clk) begin
    if (cmd.walk_clear) begin
      walk_idx <= '0;
      emit_cnt <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= walk_idx + IDX_W'(1);
      if (status.step_emit) emit_cnt <= emit_cnt + RES_CNT_W'(1);
    end
  end

  // Hold one result back until the next one or the end of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.walk_step && status.step_emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && status.step_emit) pend_idx <= walk_idx;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend || cmd.flush) begin
      expired_timer <= TIDX_W'(pend_idx);
      last_of_run   <= cmd.flush;
    end
  end

endmodule

>>> src/stb_ctrl.sv
`timescale 1ns / 1ps

module stb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  stb_pkg::ctrl_status_t status,
  output stb_pkg::ctrl_cmd_t    cmd
);
  import stb_pkg::*;

  state_t state, state_next;
  logic   step_ok;

  // A walk step waits only when it would push the held result into a full output register
  assign step_ok = !(status.step_emit && status.pend_valid && !status.out_free);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.tick_cmd) begin
            cmd.tick = 1'b1;
            if (status.expire) begin
              cmd.walk_clear = 1'b1;
              state_next     = S_WALK;
            end
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd.walking = 1'b1;
        if (step_ok) begin
          cmd.walk_step = 1'b1;
          if (status.walk_last) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // No result may be left behind once the walk is over
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !status.pend_valid)
    else $error("held result left over in idle");

  a_flush_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> status.pend_valid && status.out_free)
    else $error("flush without a held result or output room");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step && status.step_emit && status.pend_valid |-> status.out_free)
    else $error("walk step overwrites a waiting result");

  a_last_step_flushes: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && cmd.walk_step && status.walk_last |=> state == S_FLUSH)
    else $error("walk did not end after the final slot");

endmodule

>>> sim/software_timer_bank_tb.sv
`timescale 1ns / 1ps

module software_timer_bank_tb;
  import stb_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 4 * NUM_TIMERS + 8;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_TICK + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef struct packed {
    logic [TIDX_W-1:0] slot;
    logic              last;
  } timeout_t;

  // Mirror of the timer bank: slot modes, counts and the shared prescaler
  class timer_scoreboard;
    logic [DIVIDE_W-1:0]    divide;
    logic                   notify;
    mode_t                  mode [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] reload [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] remaining [NUM_TIMERS];
    logic                   restart [NUM_TIMERS];
    logic [DIVIDE_W-1:0]    prescale;
    timeout_t               due [$];
    int                     errors;

    function new();
      divide   = DIVIDE_W'(1);
      notify   = 1'b1;
      prescale = DIVIDE_W'(1);
      errors   = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        mode[i]      = MODE_STOPPED;
        reload[i]    = '0;
        remaining[i] = '0;
        restart[i]   = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TICK_DIVIDE)
        divide = data[DIVIDE_W-1:0];
      else if (idx == CFG_NOTIFY_ENABLE)
        notify = data[0];
    endfunction

    // Count down every running slot; queue a timeout per slot that hits zero
    function void walk_slots();
      timeout_t t;
      int n;
      n = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (mode[i] != MODE_RUNNING) continue;
        if (remaining[i] != 0) remaining[i] = remaining[i] - COUNT_WIDTH'(1);
        if (remaining[i] != 0) continue;
        if (restart[i])
          remaining[i] = reload[i];
        else
          mode[i] = MODE_STOPPED;
        if (notify && n < MAX_RESULTS) begin
          t.slot = TIDX_W'(i);
          t.last = 1'b0;
          due.push_back(t);
          n++;
        end
      end
      // Flag the final timeout of this tick
      if (n > 0) begin
        t = due.pop_back();
        t.last = 1'b1;
        due.push_back(t);
      end
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [TIDX_W-1:0] idx,
                            logic [PERIOD_W-1:0] per, logic ar);
      logic [COUNT_WIDTH-1:0] load;
      load = COUNT_WIDTH'(per);
      if (cmd == CMD_TICK) begin
        if (prescale != 0) prescale = prescale - DIVIDE_W'(1);
        if (prescale == 0) begin
          prescale = divide;
          walk_slots();
        end
        return;
      end
      if (int'(idx) >= NUM_TIMERS) return;
      case (cmd)
        CMD_START: begin
          if (mode[idx] == MODE_STOPPED && load != 0) begin
            reload[idx]    = load;
            remaining[idx] = load;
            restart[idx]   = ar;
            mode[idx]      = MODE_RUNNING;
          end
        end
        CMD_STOP:   mode[idx] = MODE_STOPPED;
        CMD_PAUSE:  if (mode[idx] == MODE_RUNNING) mode[idx] = MODE_PAUSED;
        CMD_RESUME: if (mode[idx] == MODE_PAUSED) mode[idx] = MODE_RUNNING;
        default: ;
      endcase
    endfunction

    function void check_timeout(logic [TIDX_W-1:0] slot, logic last);
      timeout_t want;
      if (due.size() == 0) begin
        $error("unexpected timeout item: expired_timer=%0d last_of_run=%0b", slot, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (slot !== want.slot) begin
        $error("expired_timer: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command      = '0;
  logic [TIDX_W-1:0]     timer_index  = '0;
  logic [PERIOD_W-1:0]   period       = '0;
  logic                  auto_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [TIDX_W-1:0]     expired_timer;
  logic                  last_of_run;

  timer_scoreboard sb;
  int cycles     = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;

  software_timer_bank dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .timer_index  (timer_index),
    .period       (period),
    .auto_restart (auto_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .expired_timer(expired_timer),
    .last_of_run  (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none during quiet stretches
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Watchdog; pick at random whether the next stretch is quiet
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (cycles == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check each accepted timeout item and throttle the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_timeout(expired_timer, last_of_run);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // Present one command item after a random gap and hold it until taken
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [TIDX_W-1:0] idx,
                           logic [PERIOD_W-1:0] per, logic ar);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    timer_index  <= idx;
    period       <= per;
    auto_restart <= ar;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, idx, per, ar);
  endtask

  task automatic send_random();
    int r;
    logic [CMD_W-1:0]    cmd;
    logic [PERIOD_W-1:0] per;
    r = $urandom_range(0, 99);
    if (r < 40)      cmd = CMD_TICK;
    else if (r < 66) cmd = CMD_START;
    else if (r < 76) cmd = CMD_STOP;
    else if (r < 85) cmd = CMD_PAUSE;
    else if (r < 95) cmd = CMD_RESUME;
    else             cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    // Short periods so timers expire often; some zero and some full range
    r = $urandom_range(0, 19);
    if (r == 0)     per = '0;
    else if (r < 3) per = $urandom();
    else            per = $urandom_range(1, 8);
    send_item(cmd, TIDX_W'($urandom_range(0, (1 << TIDX_W) - 1)), per,
              1'($urandom_range(0, 1)));
  endtask

  // Drop valid, drain every timeout and let any silent walk finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [DIVIDE_W-1:0] divide, logic notify);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TICK_DIVIDE;
    cfg_data  <= CFG_DATA_W'(divide);
    @(posedge clk);
    sb.write_reg(CFG_TICK_DIVIDE, CFG_DATA_W'(divide));
    cfg_index <= CFG_NOTIFY_ENABLE;
    cfg_data  <= CFG_DATA_W'(notify);
    @(posedge clk);
    sb.write_reg(CFG_NOTIFY_ENABLE, CFG_DATA_W'(notify));
    cfg_write <= 1'b0;
  endtask

  task automatic run_directed();
    // Zero period start is dropped
    send_item(CMD_START, TIDX_W'(0), '0, 1'b1);
    // Load every slot with period one: half periodic, half one-shot
    for (int i = 0; i < NUM_TIMERS; i++)
      send_item(CMD_START, TIDX_W'(i), 1, i < NUM_TIMERS / 2);
    // All slots expire in one tick, then only the periodic ones
    send_item(CMD_TICK, TIDX_W'(0), '0, 1'b0);
    send_item(CMD_TICK, TIDX_W'(0), '0, 1'b0);
    // Paused slot skips the walk
    send_item(CMD_PAUSE, TIDX_W'(0), '0, 1'b0);
    send_item(CMD_TICK, '1, '1, 1'b1);
    send_item(CMD_RESUME, TIDX_W'(0), '0, 1'b0);
    // Resume of a stopped slot and pause of a stopped slot are ignored
    send_item(CMD_RESUME, TIDX_W'(4), '0, 1'b0);
    send_item(CMD_PAUSE, TIDX_W'(5), '0, 1'b0);
    // Start on a running slot is ignored
    send_item(CMD_START, TIDX_W'(1), 5, 1'b0);
    send_item(CMD_STOP, TIDX_W'(1), '0, 1'b0);
    send_item(CMD_STOP, TIDX_W'(2), '0, 1'b0);
    send_item(CMD_STOP, TIDX_W'(6), '0, 1'b0);
    send_item(CMD_START, TIDX_W'(2), '1, 1'b0);
    // Unknown codes do nothing
    send_item(CMD_UNUSED_LO, TIDX_W'(7), 1, 1'b1);
    send_item(CMD_W'(CMD_UNUSED_LO + 1), TIDX_W'(3), '0, 1'b0);
    send_item(CMD_UNUSED_HI, TIDX_W'(0), 1, 1'b1);
    send_item(CMD_TICK, TIDX_W'(7), 1, 1'b1);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    configure(DIVIDE_W'(1), 1'b1);
    run_directed();
    repeat (100) send_random();
    settle();

    configure(DIVIDE_W'(3), 1'b1);
    repeat (60) send_random();
    settle();

    // Timeouts suppressed; counts still advance
    configure(DIVIDE_W'(1), 1'b0);
    repeat (50) send_random();
    settle();

    configure(DIVIDE_W'(2), 1'b1);
    repeat (60) send_random();
    settle();

    // Widest divide last: after its first reload no walk comes again
    configure('1, 1'b1);
    repeat (30) send_random();
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
